// ===== design/lltp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_pkg
// Shared codes and controller/datapath interface types for the linked list
// three-way partition block.
// ----------------------------------------------------------------------------
package lltp_pkg;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_FETCH = 2'd2;

	// class codes; CLS_DONE marks an exhausted result
	localparam logic [1:0] CLS_NEG  = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;
	localparam logic [1:0] CLS_DONE = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic node_we;      // load transfer: write node memory
		logic walk_init;    // start: clear queues, read head node
		logic walk_step;    // enqueue current node, read its successor
		logic fetch_first;  // fetch: latch emit point, read queue entry
		logic fetch_done;   // fetch with nothing left
		logic fetch_mid;    // read node and following queue entry
		logic fetch_emit;   // register the result
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic head_ok;      // head pointer names a node
		logic walk_more;    // successor valid and step guard not reached
		logic any_left;     // a fetch would give a result
	} status_t;

endpackage
`default_nettype wire

// ===== design/linked_list_three_way_partition.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linked_list_three_way_partition
// Stable three-way partition of a linked list held in node memory.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. A load never
// raises busy. A start stays busy while it visits nodes (none for an empty
// or out-of-range head), bounded by MAX_NODES nodes; the walk is paced by
// the registered read of the node memory, whose data feeds the next read
// address directly. A fetch reads the class queue entry at its transfer,
// then keeps busy high while the node memory and following queue entry are
// read. Its result appears on the result ports for exactly one cycle,
// flagged by result_valid, in the first cycle that busy is low again; the
// receiver cannot stall, so it must take each result as it comes. A fetch
// with nothing left gives no result. The user writes split_limit through
// cfg_write and cfg_data only while no command is in progress (unchecked).
// ----------------------------------------------------------------------------
module linked_list_three_way_partition import lltp_pkg::*; #(
	parameter int ADDR_SPACE = 131072,
	parameter int MAX_NODES  = 131072
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [1:0]  action,
	input  wire logic        [16:0] node_address,
	input  wire logic signed [17:0] node_value,
	input  wire logic signed [17:0] next_address,
	input  wire logic signed [17:0] head_address,
	input  wire logic               cfg_write,
	input  wire logic        [16:0] cfg_data,
	output logic                    result_valid,
	output logic             [16:0] out_address,
	output logic signed      [17:0] out_value,
	output logic signed      [17:0] out_next,
	output logic                    last_node
);

	cmd_t    cmd;
	status_t status;

	lltp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	lltp_datapath #(
		.ADDR_SPACE (ADDR_SPACE),
		.MAX_NODES  (MAX_NODES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.node_address (node_address),
		.node_value   (node_value),
		.next_address (next_address),
		.head_address (head_address),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.out_address  (out_address),
		.out_value    (out_value),
		.out_next     (out_next),
		.last_node    (last_node)
	);

endmodule
`default_nettype wire

// ===== design/lltp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lltp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/lltp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_ctrl
// Controller: accepts commands and sequences the walk and fetch operations.
// ----------------------------------------------------------------------------
module lltp_ctrl import lltp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	input  wire status_t    status,
	output logic            busy,
	output cmd_t            cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FQ   = 2'd2;
	localparam logic [1:0] ST_FE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_LOAD: begin
							cmd.node_we = 1'b1;
						end
						ACT_START: begin
							cmd.walk_init = 1'b1;
							if (status.head_ok) begin
								state_d = ST_WALK;
							end
						end
						ACT_FETCH: begin
							if (status.any_left) begin
								cmd.fetch_first = 1'b1;
								state_d         = ST_FQ;
							end else begin
								cmd.fetch_done = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (!status.walk_more) begin
					state_d = ST_IDLE;
				end
			end
			ST_FQ: begin
				cmd.fetch_mid = 1'b1;
				state_d       = ST_FE;
			end
			ST_FE: begin
				cmd.fetch_emit = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/lltp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lltp_datapath
// Node memory, three class queues, queue lengths, emit pointer and result
// registers of the linked list three-way partition block.
// ----------------------------------------------------------------------------
module lltp_datapath import lltp_pkg::*; #(
	parameter int ADDR_SPACE = 131072,
	parameter int MAX_NODES  = 131072
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic        [16:0] node_address,
	input  wire logic signed [17:0] node_value,
	input  wire logic signed [17:0] next_address,
	input  wire logic signed [17:0] head_address,
	input  wire logic               cfg_write,
	input  wire logic        [16:0] cfg_data,
	output logic                    result_valid,
	output logic             [16:0] out_address,
	output logic signed      [17:0] out_value,
	output logic signed      [17:0] out_next,
	output logic                    last_node
);

	localparam int AW = $clog2(ADDR_SPACE);
	localparam int PW = $clog2(MAX_NODES);
	localparam int LW = $clog2(MAX_NODES + 1);

	typedef struct packed {
		logic [1:0]    cls;
		logic [LW-1:0] pos;
	} emit_t;

	// advance past classes whose queue is used up
	function automatic emit_t skip_empty(input logic [1:0] cls, input logic [LW-1:0] pos,
			input logic [LW-1:0] l0, input logic [LW-1:0] l1, input logic [LW-1:0] l2);
		emit_t         e;
		logic [LW-1:0] len;
		e.cls = cls;
		e.pos = pos;
		for (int i = 0; i < 3; i++) begin
			unique case (e.cls)
				CLS_NEG:  len = l0;
				CLS_MID:  len = l1;
				CLS_HIGH: len = l2;
				default:  len = '0;
			endcase
			if (e.cls != CLS_DONE && e.pos >= len) begin
				e.cls = e.cls + 2'd1;
				e.pos = '0;
			end
		end
		return e;
	endfunction

	logic [16:0]   split_limit_q;
	logic [LW-1:0] len_neg_q;
	logic [LW-1:0] len_mid_q;
	logic [LW-1:0] len_high_q;
	logic [1:0]    emit_cls_q;
	logic [LW-1:0] emit_pos_q;
	logic [LW-1:0] steps_q;
	logic [16:0]   cur_q;
	logic [1:0]    cur_cls_q;
	logic [16:0]   addr_q;
	logic          valid_q;
	logic [16:0]   out_address_q;
	logic [17:0]   out_value_q;
	logic [17:0]   out_next_q;
	logic          last_q;

	logic          node_we;
	logic [AW-1:0] node_waddr;
	logic [35:0]   node_wdata;
	logic [AW-1:0] node_raddr;
	logic [35:0]   node_rdata;
	logic [17:0]   rd_value;
	logic [17:0]   rd_link;
	logic          link_ok;

	logic [2:0]    q_we;
	logic [PW-1:0] q_waddr;
	logic [PW-1:0] q_raddr;
	logic [16:0]   q_rdata [3];
	logic [1:0]    q_sel;
	logic [16:0]   q_word;

	logic [1:0]    node_cls;
	logic [LW-1:0] walk_len;
	emit_t         norm;
	emit_t         nxt;

	assign rd_value = node_rdata[35:18];
	assign rd_link  = node_rdata[17:0];

	assign status.head_ok   = !head_address[17] &&
		({15'd0, head_address[16:0]} < ADDR_SPACE);
	assign link_ok          = !rd_link[17] && ({15'd0, rd_link[16:0]} < ADDR_SPACE);
	assign status.walk_more = link_ok && (steps_q != LW'(MAX_NODES - 1));

	assign norm            = skip_empty(emit_cls_q, emit_pos_q, len_neg_q, len_mid_q, len_high_q);
	assign nxt             = skip_empty(cur_cls_q, emit_pos_q + LW'(1),
		len_neg_q, len_mid_q, len_high_q);
	assign status.any_left = (norm.cls != CLS_DONE);

	// classify the node whose data arrives this cycle
	always_comb begin
		if (rd_value[17]) begin
			node_cls = CLS_NEG;
		end else if (rd_value[16:0] <= split_limit_q) begin
			node_cls = CLS_MID;
		end else begin
			node_cls = CLS_HIGH;
		end
	end

	always_comb begin
		q_we     = '0;
		walk_len = len_neg_q;
		unique case (node_cls)
			CLS_NEG: begin
				walk_len = len_neg_q;
				q_we[0]  = cmd.walk_step;
			end
			CLS_MID: begin
				walk_len = len_mid_q;
				q_we[1]  = cmd.walk_step;
			end
			CLS_HIGH: begin
				walk_len = len_high_q;
				q_we[2]  = cmd.walk_step;
			end
			default: begin
			end
		endcase
	end

	assign q_waddr = walk_len[PW-1:0];
	assign q_raddr = cmd.fetch_first ? norm.pos[PW-1:0] : nxt.pos[PW-1:0];
	assign q_sel   = cmd.fetch_emit ? emit_cls_q : cur_cls_q;

	always_comb begin
		unique case (q_sel)
			CLS_NEG:  q_word = q_rdata[0];
			CLS_MID:  q_word = q_rdata[1];
			CLS_HIGH: q_word = q_rdata[2];
			default:  q_word = '0;
		endcase
	end

	assign node_we    = cmd.node_we && ({15'd0, node_address} < ADDR_SPACE);
	assign node_waddr = AW'({15'd0, node_address});
	assign node_wdata = {node_value, next_address};

	always_comb begin
		if (cmd.walk_init) begin
			node_raddr = AW'({15'd0, head_address[16:0]});
		end else if (cmd.fetch_mid) begin
			node_raddr = AW'({15'd0, q_word});
		end else begin
			node_raddr = AW'({15'd0, rd_link[16:0]});
		end
	end

	lltp_ram #(
		.WIDTH (36),
		.DEPTH (ADDR_SPACE)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	for (genvar g = 0; g < 3; g++) begin : g_queue
		lltp_ram #(
			.WIDTH (17),
			.DEPTH (MAX_NODES)
		) u_queue_ram (
			.clk   (clk),
			.we    (q_we[g]),
			.waddr (q_waddr),
			.wdata (cur_q),
			.raddr (q_raddr),
			.rdata (q_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_limit_q <= '0;
			len_neg_q     <= '0;
			len_mid_q     <= '0;
			len_high_q    <= '0;
			emit_cls_q    <= CLS_NEG;
			emit_pos_q    <= '0;
			steps_q       <= '0;
			valid_q       <= 1'b0;
		end else begin
			valid_q <= cmd.fetch_emit;
			if (cfg_write) begin
				split_limit_q <= cfg_data;
			end
			if (cmd.walk_init) begin
				len_neg_q  <= '0;
				len_mid_q  <= '0;
				len_high_q <= '0;
				emit_cls_q <= CLS_NEG;
				emit_pos_q <= '0;
				steps_q    <= '0;
			end
			if (cmd.walk_step) begin
				steps_q <= steps_q + LW'(1);
				unique case (node_cls)
					CLS_NEG:  len_neg_q  <= len_neg_q + LW'(1);
					CLS_MID:  len_mid_q  <= len_mid_q + LW'(1);
					CLS_HIGH: len_high_q <= len_high_q + LW'(1);
					default: begin
					end
				endcase
			end
			if (cmd.fetch_first) begin
				emit_cls_q <= norm.cls;
				emit_pos_q <= norm.pos;
			end
			if (cmd.fetch_done) begin
				emit_cls_q <= CLS_DONE;
				emit_pos_q <= '0;
			end
			if (cmd.fetch_mid) begin
				emit_cls_q <= nxt.cls;
				emit_pos_q <= nxt.pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			cur_q <= head_address[16:0];
		end
		if (cmd.walk_step) begin
			cur_q <= rd_link[16:0];
		end
		if (cmd.fetch_first) begin
			cur_cls_q <= norm.cls;
		end
		if (cmd.fetch_mid) begin
			addr_q <= q_word;
		end
		if (cmd.fetch_emit) begin
			out_address_q <= addr_q;
			out_value_q   <= rd_value;
			if (emit_cls_q == CLS_DONE) begin
				out_next_q <= '1;
				last_q     <= 1'b1;
			end else begin
				out_next_q <= {1'b0, q_word};
				last_q     <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign out_address  = out_address_q;
	assign out_value    = out_value_q;
	assign out_next     = out_next_q;
	assign last_node    = last_q;

`ifndef SYNTHESIS
	a_one_queue_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(q_we))
		else $error("more than one class queue written in a cycle");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(len_neg_q) + 32'(len_mid_q) + 32'(len_high_q)) <= 32'(MAX_NODES))
		else $error("class lengths exceed the node limit");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(q_we != 3'b000) |-> (walk_len < LW'(MAX_NODES)))
		else $error("queue write beyond queue depth");

	a_last_matches_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_node == (emit_cls_q == CLS_DONE)))
		else $error("last flag disagrees with emit pointer");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linked list three-way partition block. Loads
// node memory, walks lists under several split_limit settings and fetches the
// partitioned order; every emitted node is compared against a scoreboard that
// keeps its own node memory and class queues.
// ----------------------------------------------------------------------------
module tb_top import lltp_pkg::*; ();

	localparam int ADDR_SPACE  = 131072;
	localparam int MAX_NODES   = 131072;
	localparam int STALL_LIMIT = 4 * MAX_NODES;
	localparam int PHASE_ITEMS = 210;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic        [16:0] addr;
		logic signed [17:0] value;
		logic signed [17:0] follow;
		logic               last;
	} node_result_t;

	class partition_scoreboard;
		logic signed [17:0] value_mem[int];
		logic signed [17:0] link_mem[int];
		logic        [16:0] class_q[3][$];
		logic        [16:0] split_limit = '0;
		logic        [1:0]  emit_cls = CLS_NEG;
		int                 emit_pos = 0;
		node_result_t       pending[$];
		int                 errors = 0;
		int                 checked = 0;
		int                 longest_walk = 0;

		function void skip_exhausted(inout logic [1:0] c, inout int p);
			while (c != CLS_DONE && p >= class_q[c].size()) begin
				c = c + 2'd1;
				p = 0;
			end
		endfunction

		function void walk_list(logic signed [17:0] head);
			int cur;
			int v;
			int steps;
			for (int k = 0; k < 3; k++)
				class_q[k].delete();
			cur = head;
			for (steps = 0; steps < MAX_NODES; steps++) begin
				if (cur < 0 || cur >= ADDR_SPACE)
					break;
				v = value_mem[cur];
				if (v < 0)
					class_q[CLS_NEG].insert(class_q[CLS_NEG].size(), 17'(cur));
				else if (v <= int'(split_limit))
					class_q[CLS_MID].insert(class_q[CLS_MID].size(), 17'(cur));
				else
					class_q[CLS_HIGH].insert(class_q[CLS_HIGH].size(), 17'(cur));
				cur = link_mem[cur];
			end
			if (steps > longest_walk)
				longest_walk = steps;
			emit_cls = CLS_NEG;
			emit_pos = 0;
		endfunction

		function void fetch_node();
			logic [1:0]   c;
			int           p;
			node_result_t r;
			c = emit_cls;
			p = emit_pos;
			skip_exhausted(c, p);
			if (c == CLS_DONE) begin
				emit_cls = CLS_DONE;
				emit_pos = 0;
				return;
			end
			r.addr = class_q[c][p];
			p++;
			skip_exhausted(c, p);
			emit_cls = c;
			emit_pos = p;
			r.value = value_mem[int'(r.addr)];
			if (c == CLS_DONE) begin
				r.follow = '1;
				r.last = 1'b1;
			end else begin
				r.follow = {1'b0, class_q[c][p]};
				r.last = 1'b0;
			end
			pending.insert(pending.size(), r);
		endfunction

		// called once per accepted command transfer
		function void note_command(logic [1:0] act, logic [16:0] addr,
				logic signed [17:0] val, logic signed [17:0] nxt, logic signed [17:0] hd);
			case (act)
				ACT_LOAD: begin
					value_mem[int'(addr)] = val;
					link_mem[int'(addr)] = nxt;
				end
				ACT_START: walk_list(hd);
				ACT_FETCH: fetch_node();
				default: ;
			endcase
		endfunction

		function int nodes_left();
			int n = 0;
			if (emit_cls == CLS_DONE)
				return 0;
			for (int k = emit_cls; k < 3; k++)
				n += class_q[k].size();
			return n - emit_pos;
		endfunction

		function void check_emitted(logic [16:0] addr, logic signed [17:0] val,
				logic signed [17:0] follow, logic last);
			node_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, address %0d value %0d", $time, addr, val);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (addr !== e.addr) begin
				$display("%0t: out_address expected %0d got %0d", $time, e.addr, addr);
				errors++;
			end
			if (val !== e.value) begin
				$display("%0t: out_value expected %0d got %0d", $time, e.value, val);
				errors++;
			end
			if (follow !== e.follow) begin
				$display("%0t: out_next expected %0d got %0d", $time, e.follow, follow);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_node expected %0d got %0d", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [1:0]  action;
	logic        [16:0] node_address;
	logic signed [17:0] node_value;
	logic signed [17:0] next_address;
	logic signed [17:0] head_address;
	logic               cfg_write;
	logic        [16:0] cfg_data;
	logic               result_valid;
	logic        [16:0] out_address;
	logic signed [17:0] out_value;
	logic signed [17:0] out_next;
	logic               last_node;

	partition_scoreboard sb = new;
	logic [16:0] known_addrs[$];
	bit          no_gaps;
	int          command_count;
	int          setting_count;
	int          idle_run;

	linked_list_three_way_partition #(
		.ADDR_SPACE(ADDR_SPACE),
		.MAX_NODES (MAX_NODES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.node_address(node_address),
		.node_value  (node_value),
		.next_address(next_address),
		.head_address(head_address),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.out_address (out_address),
		.out_value   (out_value),
		.out_next    (out_next),
		.last_node   (last_node)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_emitted(out_address, out_value, out_next, last_node);
	end

	// watchdog: no transfer of any kind for too long
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_write)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_run);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [17:0] any18();
		return 18'($urandom);
	endfunction

	function automatic logic signed [17:0] end_pointer();
		if ($urandom_range(0, 3) == 0)
			return 18'(-$urandom_range(1, 131072));
		return '1;
	endfunction

	function automatic logic signed [17:0] pick_value();
		int lim = sb.split_limit;
		case ($urandom_range(0, 7))
			0, 1: return 18'(-$urandom_range(1, 131072));
			2, 3, 4: return 18'($urandom_range(0, lim));
			5, 6: begin
				if (lim < 131071)
					return 18'($urandom_range(lim + 1, 131071));
				return 18'($urandom_range(0, 131071));
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return -18'sd131072;
					1: return -18'sd1;
					2: return 18'sd0;
					3: return 18'(lim);
					4: return 18'(lim + 1);
					default: return 18'sd131071;
				endcase
			end
		endcase
	endfunction

	// start stays high across back-to-back transfers; it is lowered only for a gap
	task automatic issue(input logic [1:0] act, input logic [16:0] addr,
			input logic signed [17:0] val, input logic signed [17:0] nxt,
			input logic signed [17:0] hd);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		node_address <= addr;
		node_value <= val;
		next_address <= nxt;
		head_address <= hd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(act, addr, val, nxt, hd);
		if (act != ACT_NONE)
			command_count++;
	endtask

	task automatic load_node(input logic [16:0] addr, input logic signed [17:0] val,
			input logic signed [17:0] nxt);
		if (!sb.value_mem.exists(int'(addr)))
			known_addrs.insert(known_addrs.size(), addr);
		issue(ACT_LOAD, addr, val, nxt, any18());
	endtask

	task automatic begin_walk(input logic signed [17:0] hd);
		issue(ACT_START, 17'($urandom), any18(), any18(), hd);
	endtask

	task automatic fetch();
		issue(ACT_FETCH, 17'($urandom), any18(), any18(), any18());
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (busy || sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_split_limit(input logic [16:0] lim);
		wait_quiet();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= lim;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.split_limit = lim;
		setting_count++;
	endtask

	// new value for a known node; its link is kept so no loop can form
	task automatic retouch_node();
		logic [16:0] a;
		a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
		load_node(a, pick_value(), sb.link_mem[int'(a)]);
	endtask

	task automatic stray_load();
		logic [16:0] a;
		if ($urandom_range(0, 1) == 0) begin
			retouch_node();
			return;
		end
		do
			a = 17'($urandom);
		while (sb.value_mem.exists(int'(a)));
		// a fresh node has no predecessor, so pointing it into a known list is safe
		if ($urandom_range(0, 1) == 0)
			load_node(a, pick_value(), end_pointer());
		else
			load_node(a, pick_value(),
				{1'b0, known_addrs[$urandom_range(0, known_addrs.size() - 1)]});
	endtask

	task automatic random_round();
		logic        [16:0] chain[$];
		bit                 taken[int];
		logic        [16:0] a;
		logic signed [17:0] link;
		logic signed [17:0] head;
		int                 len;
		int                 n;
		no_gaps = ($urandom_range(0, 3) == 0);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
		for (int i = 0; i < len; i++) begin
			do begin
				if (known_addrs.size() > 0 && $urandom_range(0, 2) == 0)
					a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
				else
					a = 17'($urandom);
			end while (taken.exists(int'(a)));
			taken[int'(a)] = 1'b1;
			chain.insert(chain.size(), a);
		end
		// tail first, so every link names a node already written
		link = end_pointer();
		for (int i = len - 1; i >= 0; i--) begin
			load_node(chain[i], pick_value(), link);
			link = {1'b0, chain[i]};
			if ($urandom_range(0, 7) == 0)
				stray_load();
		end
		case ($urandom_range(0, 9))
			0: head = end_pointer();
			1: head = {1'b0, known_addrs[$urandom_range(0, known_addrs.size() - 1)]};
			default: head = {1'b0, chain[0]};
		endcase
		begin_walk(head);
		n = sb.nodes_left() + $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 39))
				0: retouch_node();
				1: issue(ACT_NONE, 17'($urandom), any18(), any18(), any18());
				2: begin_walk(head);
				default: ;
			endcase
			fetch();
		end
	endtask

	initial begin
		logic [16:0] limits[6];
		int          phase_end;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_LOAD;
		node_address = '0;
		node_value = '0;
		next_address = '0;
		head_address = '1;
		cfg_write = 1'b0;
		cfg_data = '0;
		no_gaps = 1'b0;
		command_count = 0;
		setting_count = 0;
		idle_run = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		set_split_limit(17'd5);
		fetch();                                   // nothing walked yet
		issue(ACT_NONE, 17'h1FFFF, '1, '1, '1);
		load_node(17'd8, -18'sd1, -18'sd1);
		load_node(17'd7, 18'sd6, 18'sd8);
		load_node(17'd6, 18'sd5, 18'sd7);
		load_node(17'd5, 18'sd0, 18'sd6);
		load_node(17'h1FFFF, 18'sd131071, 18'sd5);
		load_node(17'd0, -18'sd131072, 18'sd131071);
		begin_walk(18'sd0);
		fetch();
		fetch();
		fetch();
		// built order is fixed; only the reported value follows the load
		load_node(17'h1FFFF, -18'sd77, 18'sd5);
		fetch();
		fetch();
		fetch();
		load_node(17'd9, 18'sd3, -18'sd131072);    // any negative link ends a walk
		begin_walk(18'sd9);
		fetch();
		fetch();
		begin_walk(-18'sd1);
		fetch();
		// two-node loop: the walk runs into the step guard
		load_node(17'd20, -18'sd3, 18'sd21);
		load_node(17'd21, 18'sd100, 18'sd20);
		begin_walk(18'sd20);
		fetch();
		fetch();
		load_node(17'd20, -18'sd3, -18'sd1);
		load_node(17'd21, 18'sd100, -18'sd1);

		// random part, one phase per split_limit setting
		limits = '{17'd0, 17'h1FFFF, 17'd1, 17'd65535,
			17'($urandom_range(2, 131070)), 17'd255};
		foreach (limits[i]) begin
			set_split_limit(limits[i]);
			phase_end = command_count + PHASE_ITEMS;
			while (command_count < phase_end)
				random_round();
		end

		wait_quiet();
		repeat (16) @(posedge clk);
		$display("Sent %0d commands over %0d split_limit settings; %0d nodes checked.",
			command_count, setting_count, sb.checked);
		$display("Longest walk %0d nodes, %0d known node addresses.",
			sb.longest_walk, known_addrs.size());
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lltp_pkg.sv
design/lltp_ram.sv
design/lltp_ctrl.sv
design/lltp_datapath.sv
design/linked_list_three_way_partition.sv
test/tb_top.sv
